[hw/rtl/ctt_pkg.sv]
package ctt_pkg;

    localparam int MaxToken = 256;
    localparam int CntW     = $clog2(MaxToken);

    localparam logic [CntW-1:0] KeepLimit = CntW'(MaxToken - 1);

    // character codes
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [1:0] KIND_WORD   = 2'd0;
    localparam logic [1:0] KIND_STRING = 2'd1;
    localparam logic [1:0] KIND_SINGLE = 2'd2;

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_COMMENT = 6'b000010,
        MODE_SLASH   = 6'b000100,
        MODE_WORD    = 6'b001000,
        MODE_STR     = 6'b010000,
        MODE_STR_ESC = 6'b100000
    } t_mode;

    typedef struct packed {
        t_mode           mode;
        logic [7:0]      held_byte;
        logic            held_valid;
        logic [CntW-1:0] kept_count;
        logic [1:0]      kind;
    } t_lex_state;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [7:0] count;
        logic [1:0] kind;
    } t_result;

    // up to three result beats from one input beat
    typedef struct packed {
        logic [1:0]       n;
        t_result [2:0]    res;
    } t_push;

    typedef struct packed {
        t_lex_state st;
        t_push      push;
    } t_step;

    localparam t_lex_state LexReset = '{
        mode:       MODE_IDLE,
        held_byte:  8'd0,
        held_valid: 1'b0,
        kept_count: '0,
        kind:       KIND_WORD
    };

    function automatic logic [7:0] cnt8(input logic [CntW-1:0] c);
        logic [CntW+7:0] w;
        w = {8'd0, c};
        return w[7:0];
    endfunction

    function automatic logic is_single(input logic [7:0] b);
        return b == CH_LBRACE || b == CH_RBRACE || b == CH_LBRACK ||
               b == CH_RBRACK || b == CH_LPAREN || b == CH_RPAREN ||
               b == CH_COMMA  || b == CH_APOS   || b == CH_EQUAL;
    endfunction

    function automatic t_step put(input t_step x, input logic [7:0] b,
                                  input logic last, input logic [7:0] cnt,
                                  input logic [1:0] kind);
        t_step y;
        y = x;
        if (x.push.n != 2'd3) begin
            y.push.res[x.push.n].data  = b;
            y.push.res[x.push.n].last  = last;
            y.push.res[x.push.n].count = cnt;
            y.push.res[x.push.n].kind  = kind;
            y.push.n = x.push.n + 2'd1;
        end
        return y;
    endfunction

    // send the previous held byte, hold the new one; drop once full
    function automatic t_step keep(input t_step x, input logic [7:0] b);
        t_step y;
        y = x;
        if (x.st.kept_count < KeepLimit) begin
            if (x.st.held_valid) begin
                y = put(y, x.st.held_byte, 1'b0, cnt8(x.st.kept_count), x.st.kind);
            end
            y.st.held_byte  = b;
            y.st.held_valid = 1'b1;
            y.st.kept_count = x.st.kept_count + CntW'(1);
        end
        return y;
    endfunction

    function automatic t_step close(input t_step x);
        t_step y;
        y = x;
        if (x.st.held_valid) begin
            y = put(y, x.st.held_byte, 1'b1, cnt8(x.st.kept_count), x.st.kind);
        end
        y.st = LexReset;
        return y;
    endfunction

    function automatic t_step word_byte(input t_step x, input logic [7:0] b);
        t_step y;
        y = x;
        if (b <= CH_SPACE) begin
            y = close(y);
        end else if (is_single(b)) begin
            y = close(y);
            y = put(y, b, 1'b1, 8'd1, KIND_SINGLE);
        end else begin
            y = keep(y, b);
        end
        return y;
    endfunction

    function automatic t_step string_byte(input t_step x, input logic [7:0] b);
        t_step y;
        y = x;
        if (b == CH_BSLASH) begin
            y.st.mode = MODE_STR_ESC;
        end else begin
            y = keep(y, b);
            if (b == CH_QUOTE) begin
                y = close(y);
            end
        end
        return y;
    endfunction

    function automatic t_step idle_byte(input t_step x, input logic [7:0] b);
        t_step y;
        y = x;
        y.st.mode = MODE_IDLE;
        if (b <= CH_SPACE) begin
            y = x;
            y.st.mode = MODE_IDLE;
        end else if (b == CH_SEMI || b == CH_HASH) begin
            y.st.mode = MODE_COMMENT;
        end else if (b == CH_SLASH) begin
            y.st.mode = MODE_SLASH;
        end else if (b == CH_QUOTE) begin
            y.st.kind = KIND_STRING;
            y.st.mode = MODE_STR;
            y = keep(y, b);
        end else if (is_single(b)) begin
            y = put(y, b, 1'b1, 8'd1, KIND_SINGLE);
        end else begin
            y.st.kind = KIND_WORD;
            y.st.mode = MODE_WORD;
            y = keep(y, b);
        end
        return y;
    endfunction

    function automatic t_step lex_step(input t_lex_state s, input logic [7:0] b,
                                       input logic fin);
        t_step x;
        x.st   = s;
        x.push = '0;
        if (fin) begin
            if (s.mode == MODE_SLASH) begin
                x.st.kind = KIND_WORD;
                x = keep(x, CH_SLASH);
            end else if (s.mode == MODE_STR_ESC) begin
                x = keep(x, CH_BSLASH);
            end
            x = close(x);
        end else begin
            unique case (s.mode)
                MODE_COMMENT: begin
                    if (b == CH_LF) begin
                        x.st.mode = MODE_IDLE;
                    end
                end
                MODE_SLASH: begin
                    if (b == CH_SLASH) begin
                        x.st.mode = MODE_COMMENT;
                    end else begin
                        x.st.kind = KIND_WORD;
                        x.st.mode = MODE_WORD;
                        x = keep(x, CH_SLASH);
                        x = word_byte(x, b);
                    end
                end
                MODE_WORD: begin
                    x = word_byte(x, b);
                end
                MODE_STR: begin
                    x = string_byte(x, b);
                end
                MODE_STR_ESC: begin
                    x.st.mode = MODE_STR;
                    if (b == CH_QUOTE) begin
                        x = keep(x, b);
                    end else begin
                        x = keep(x, CH_BSLASH);
                        x = string_byte(x, b);
                    end
                end
                default: begin
                    x = idle_byte(x, b);
                end
            endcase
        end
        return x;
    endfunction

endpackage

[hw/rtl/ctt_lex.sv]
module ctt_lex (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_byte,
    input  logic            i_end,
    input  logic            i_room,
    output ctt_pkg::t_push  o_push
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_end;
    ctt_pkg::t_lex_state   r_st;
    ctt_pkg::t_step        step;
    logic                  consume;
    logic                  accept;

    assign consume = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        step = ctt_pkg::lex_step(r_st, r_in_byte, r_in_end);
    end

    always_comb begin
        o_push = step.push;
        if (!consume) begin
            o_push.n = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_st       <= ctt_pkg::LexReset;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_st <= step.st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_byte;
            r_in_end  <= i_end;
        end
    end

endmodule

[hw/rtl/ctt_outq.sv]
module ctt_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctt_pkg::t_push    i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_stall,
    output ctt_pkg::t_result  o_res
);

    ctt_pkg::t_result [3:0] r_q;
    ctt_pkg::t_result [3:0] n_q;
    logic [2:0]             r_cnt;
    logic [2:0]             n_cnt;
    logic [2:0]             base;
    logic [2:0]             off;
    logic                   pop;

    assign o_valid = r_cnt != 3'd0;
    assign o_res   = r_q[0];
    assign pop     = o_valid && !i_stall;
    // a full three-beat push must fit whatever the drain side does
    assign o_room  = r_cnt <= 3'd1;
    assign base    = r_cnt - {2'd0, pop};
    assign n_cnt   = base + {1'b0, i_push.n};

    always_comb begin
        n_q = r_q;
        off = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (pop && i < 3) begin
                n_q[i] = r_q[i+1];
            end
            off = 3'(i) - base;
            if (3'(i) >= base && off < {1'b0, i_push.n}) begin
                n_q[i] = i_push.res[off[1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

[hw/rtl/config_text_tokenizer_unit.sv]
// Path: a taken input beat is registered at the lexer stage and lexed once the queue has
// room; its result beats are registered in the queue that drives the output. The last byte
// of a word or string is held until the next byte or end of text shows the token closed.
// Throughput: one input beat per cycle while results drain one beat per cycle; the
// four-entry result queue pauses input for steps that make two or three beats.
// Reset: synchronous, active low; returns to idle between tokens with an empty queue.
module config_text_tokenizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic [7:0] o_out_count,
    output logic [1:0] o_out_kind
);

    ctt_pkg::t_push   push;
    ctt_pkg::t_result res;
    logic             room;

    ctt_lex u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_byte  (i_in_byte),
        .i_end   (i_in_end),
        .i_room  (room),
        .o_push  (push)
    );

    ctt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (res)
    );

    assign o_out_byte  = res.data;
    assign o_out_last  = res.last;
    assign o_out_count = res.count;
    assign o_out_kind  = res.kind;

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.n != 2'd0 |-> room)
        else $error("result push without queue room");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == ctt_pkg::KIND_SINGLE |->
            o_out_last && o_out_count == 8'd1)
        else $error("single-character token not a one-byte last beat");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

[dv/config_text_tokenizer_unit_tb.sv]
`timescale 1ns / 1ps

module config_text_tokenizer_unit_tb;
    import ctt_pkg::*;

    localparam int CycleLimit = 100000;
    localparam int HoldCycles = 80;

    class token_board;
        t_mode      mode;
        logic [7:0] held;
        logic       held_ok;
        int         kept;
        logic [1:0] kind;
        t_result    token_bytes_due[$];
        int         errors;
        int         checked;
        int         tokens;

        function new();
            mode    = MODE_IDLE;
            held    = 8'd0;
            held_ok = 1'b0;
            kept    = 0;
            kind    = KIND_WORD;
            errors  = 0;
            checked = 0;
            tokens  = 0;
        endfunction

        static function logic is_punct(input logic [7:0] b);
            return b inside {CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_LPAREN,
                             CH_RPAREN, CH_COMMA, CH_APOS, CH_EQUAL};
        endfunction

        function void emit(input logic [7:0] b, input logic lst, input logic [7:0] cnt,
                           input logic [1:0] k);
            t_result r;
            r.data  = b;
            r.last  = lst;
            r.count = cnt;
            r.kind  = k;
            token_bytes_due.push_back(r);
        endfunction

        // release the previous held byte, hold the new one; drop once the token is full
        function void keep_byte(input logic [7:0] b);
            if (kept < MaxToken - 1) begin
                if (held_ok) emit(held, 1'b0, 8'(kept), kind);
                held    = b;
                held_ok = 1'b1;
                kept++;
            end
        endfunction

        function void close_tok();
            if (held_ok) emit(held, 1'b1, 8'(kept), kind);
            held    = 8'd0;
            held_ok = 1'b0;
            kept    = 0;
            kind    = KIND_WORD;
            mode    = MODE_IDLE;
        endfunction

        function void word_in(input logic [7:0] b);
            if (b <= CH_SPACE) begin
                close_tok();
            end else if (is_punct(b)) begin
                close_tok();
                emit(b, 1'b1, 8'd1, KIND_SINGLE);
            end else begin
                keep_byte(b);
            end
        endfunction

        function void str_in(input logic [7:0] b);
            if (b == CH_BSLASH) begin
                mode = MODE_STR_ESC;
            end else begin
                keep_byte(b);
                if (b == CH_QUOTE) close_tok();
            end
        endfunction

        function void idle_in(input logic [7:0] b);
            mode = MODE_IDLE;
            if (b <= CH_SPACE) begin
                return;
            end else if (b == CH_SEMI || b == CH_HASH) begin
                mode = MODE_COMMENT;
            end else if (b == CH_SLASH) begin
                mode = MODE_SLASH;
            end else if (b == CH_QUOTE) begin
                kind = KIND_STRING;
                mode = MODE_STR;
                keep_byte(b);
            end else if (is_punct(b)) begin
                emit(b, 1'b1, 8'd1, KIND_SINGLE);
            end else begin
                kind = KIND_WORD;
                mode = MODE_WORD;
                keep_byte(b);
            end
        endfunction

        function void note_text_beat(input logic [7:0] b, input logic fin);
            if (fin) begin
                if (mode == MODE_SLASH) begin
                    kind = KIND_WORD;
                    keep_byte(CH_SLASH);
                end else if (mode == MODE_STR_ESC) begin
                    keep_byte(CH_BSLASH);
                end
                close_tok();
                return;
            end
            case (mode)
                MODE_COMMENT: begin
                    if (b == CH_LF) mode = MODE_IDLE;
                end
                MODE_SLASH: begin
                    if (b == CH_SLASH) begin
                        mode = MODE_COMMENT;
                    end else begin
                        kind = KIND_WORD;
                        mode = MODE_WORD;
                        keep_byte(CH_SLASH);
                        word_in(b);
                    end
                end
                MODE_WORD: word_in(b);
                MODE_STR:  str_in(b);
                MODE_STR_ESC: begin
                    mode = MODE_STR;
                    if (b == CH_QUOTE) begin
                        keep_byte(b);
                    end else begin
                        keep_byte(CH_BSLASH);
                        str_in(b);
                    end
                end
                default: idle_in(b);
            endcase
        endfunction

        function void field_check(input string name, input int want, input int got);
            if (want != got) begin
                errors++;
                if (errors <= 40)
                    $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name,
                             want, got);
            end
        endfunction

        function void check_token_beat(input t_result got);
            t_result want;
            checked++;
            if (got.last) tokens++;
            if (token_bytes_due.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t unexpected token beat: expected none, actual %0h/%0b/%0d/%0d",
                             $time, got.data, got.last, got.count, got.kind);
                return;
            end
            want = token_bytes_due.pop_front();
            field_check("byte",  want.data,  got.data);
            field_check("last",  want.last,  got.last);
            field_check("count", want.count, got.count);
            field_check("kind",  want.kind,  got.kind);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       i_in_end;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic [7:0] o_out_count;
    logic [1:0] o_out_kind;

    token_board  board = new();
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          beats_sent = 0;
    int unsigned cycle_count = 0;
    logic        hold_rx = 1'b0;
    logic        squeeze_go = 1'b0;

    logic [7:0] single_chars [9] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_LPAREN,
                                     CH_RPAREN, CH_COMMA, CH_APOS, CH_EQUAL};

    config_text_tokenizer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_end    (i_in_end),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_out_count (o_out_count),
        .o_out_kind  (o_out_kind)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output side: check accepted beats, pick the stall for the next cycle
    always @(posedge i_clk) begin : rx_side
        t_result seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.data  = o_out_byte;
            seen.last  = o_out_last;
            seen.count = o_out_count;
            seen.kind  = o_out_kind;
            board.check_token_beat(seen);
        end
        i_out_stall <= hold_rx || ($urandom_range(0, 99) < rx_stall_pct);
    end

    // long hold-off so the result queue fills and the input backs up
    initial begin
        wait (squeeze_go);
        hold_rx <= 1'b1;
        repeat (HoldCycles) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    task automatic send_beat(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_end   <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_text_beat(b, fin);
        beats_sent++;
    endtask

    task automatic send_char(input logic [7:0] b);
        send_beat(b, 1'b0);
    endtask

    task automatic send_eot();
        send_beat(8'($urandom), 1'b1);
    endtask

    function automatic logic [7:0] word_char(input logic first);
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(33, 255));
            else c = 8'($urandom_range(97, 122));
        end while (token_board::is_punct(c) ||
                   (first && (c == CH_SEMI || c == CH_HASH || c == CH_SLASH ||
                              c == CH_QUOTE)));
        return c;
    endfunction

    function automatic logic [7:0] string_char();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    task automatic send_fragment();
        int         pick;
        int         len;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            len = $urandom_range(1, 8);
            send_char(word_char(1'b1));
            repeat (len - 1) send_char(word_char(1'b0));
        end else if (pick < 40) begin
            send_char(8'($urandom_range(0, 32)));
        end else if (pick < 52) begin
            send_char(single_chars[$urandom_range(0, 8)]);
        end else if (pick < 67) begin
            send_char(CH_QUOTE);
            len = $urandom_range(0, 8);
            repeat (len) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_char(CH_BSLASH);
                    case ($urandom_range(0, 2))
                        0:       send_char(CH_QUOTE);
                        1:       send_char(CH_BSLASH);
                        default: send_char(8'($urandom));
                    endcase
                end else begin
                    send_char(string_char());
                end
            end
            if ($urandom_range(0, 9) != 0) send_char(CH_QUOTE);
        end else if (pick < 77) begin
            case ($urandom_range(0, 2))
                0: send_char(CH_SEMI);
                1: send_char(CH_HASH);
                default: begin
                    send_char(CH_SLASH);
                    send_char(CH_SLASH);
                end
            endcase
            len = $urandom_range(0, 6);
            repeat (len) begin
                do c = 8'($urandom); while (c == CH_LF);
                send_char(c);
            end
            send_char(CH_LF);
        end else if (pick < 82) begin
            send_char(CH_SLASH);
            do c = 8'($urandom); while (c == CH_SLASH);
            send_char(c);
        end else if (pick < 95) begin
            send_char(8'($urandom));
        end else begin
            send_eot();
        end
    endtask

    task automatic run_text(input int beats);
        int stop_at;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) send_fragment();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_byte   = 8'd0;
        i_in_end    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // word with a top-bit byte cut by a single; string with both escape forms
        send_char("a"); send_char(8'hFF); send_char(CH_EQUAL);
        send_char(CH_QUOTE); send_char("x"); send_char(CH_BSLASH); send_char(CH_QUOTE);
        send_char(CH_BSLASH); send_char("n"); send_char(CH_QUOTE);
        // comments, lone slash, comment characters inside a word
        send_char(CH_SEMI); send_char("z"); send_char(CH_LF);
        send_char(CH_SLASH); send_char("q"); send_char(CH_LBRACE);
        send_char(CH_SLASH); send_char(CH_SLASH); send_char(CH_LF);
        send_char("k"); send_char(CH_HASH); send_char(CH_SLASH); send_char(8'h00);
        // end of text with a pending slash, a pending backslash, and in idle
        send_char(CH_SLASH); send_eot();
        send_char(CH_QUOTE); send_char(CH_BSLASH); send_eot();
        send_eot();

        run_text(40);

        tx_idle_pct = 58;
        run_text(40);

        tx_idle_pct  = 0;
        rx_stall_pct = 58;
        run_text(40);

        tx_idle_pct  = 33;
        rx_stall_pct = 33;
        run_text(40);

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        squeeze_go   = 1'b1;
        run_text(40);
        send_eot();
        i_in_valid <= 1'b0;

        while (board.token_bytes_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("Lexed %0d text beats under five flow-control mixes and a long output hold.",
                 beats_sent);
        $display("Checked %0d token bytes closing %0d tokens, escapes and comments included.",
                 board.checked, board.tokens);
        if (board.errors == 0 && board.token_bytes_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/ctt_pkg.sv
hw/rtl/ctt_lex.sv
hw/rtl/ctt_outq.sv
hw/rtl/config_text_tokenizer_unit.sv
dv/config_text_tokenizer_unit_tb.sv
